/* design/utf8_utf32_codepoint_convert_defines.svh */
// ----------------------------------------------------------------------------
// utf8_utf32_codepoint_convert_defines.svh
// assertion macros shared by the converter rtl
// ----------------------------------------------------------------------------
`ifndef UTF8_UTF32_CODEPOINT_CONVERT_DEFINES_SVH
`define UTF8_UTF32_CODEPOINT_CONVERT_DEFINES_SVH

// plain property, sampled on clk_i, off while rst_ni is low
`define U8U_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// same-cycle implication
`define U8U_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define U8U_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

/* design/u8u32cc_pkg.sv */
// ----------------------------------------------------------------------------
// u8u32cc_pkg
// types and constants of the utf-8 / utf-32 code point converter
// ----------------------------------------------------------------------------
package u8u32cc_pkg;

  typedef enum logic {
    OP_DECODE = 1'b0,
    OP_ENCODE = 1'b1
  } op_e;

  localparam logic [2:0] MAX_WIN = 3'd4;

  localparam logic [7:0] ASCII_MAX    = 8'h7F;
  localparam logic [7:0] CONT_MIN     = 8'h80;
  localparam logic [7:0] CONT_MAX     = 8'hBF;
  localparam logic [7:0] LEAD2_MIN    = 8'hC2;
  localparam logic [7:0] LEAD2_MAX    = 8'hDF;
  localparam logic [7:0] LEAD3_MIN    = 8'hE0;
  localparam logic [7:0] LEAD3_MAX    = 8'hEF;
  localparam logic [7:0] LEAD_SURR    = 8'hED;
  localparam logic [7:0] LEAD4_MIN    = 8'hF0;
  localparam logic [7:0] LEAD4_MAX    = 8'hF4;
  localparam logic [7:0] E0_CONT_MIN  = 8'hA0;
  localparam logic [7:0] ED_CONT_MAX  = 8'h9F;
  localparam logic [7:0] F0_CONT_MIN  = 8'h90;
  localparam logic [7:0] F4_CONT_MAX  = 8'h8F;

  localparam logic [31:0] ONE_BYTE_MAX   = 32'h0000_007F;
  localparam logic [31:0] TWO_BYTE_MAX   = 32'h0000_07FF;
  localparam logic [31:0] THREE_BYTE_MAX = 32'h0000_FFFF;
  localparam logic [31:0] SURR_MIN       = 32'h0000_D800;
  localparam logic [31:0] SURR_MAX       = 32'h0000_DFFF;
  localparam logic [31:0] MAX_CODE_POINT = 32'h0010_FFFF;

  typedef struct packed {
    logic        ok;
    logic [2:0]  length;
    logic [20:0] code_out;
    logic [7:0]  out_byte0;
    logic [7:0]  out_byte1;
    logic [7:0]  out_byte2;
    logic [7:0]  out_byte3;
    logic [2:0]  subpart_len;
  } res_t;

endpackage

/* design/u8u32cc_if.sv */
// ----------------------------------------------------------------------------
// u8u32cc_if
// valid/ready channels of the code point converter
// ----------------------------------------------------------------------------
interface u8u32cc_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  in_byte0;
  logic [7:0]  in_byte1;
  logic [7:0]  in_byte2;
  logic [7:0]  in_byte3;
  logic [2:0]  avail_bytes;
  logic [31:0] code_in;

  modport source (
    output valid, opcode, in_byte0, in_byte1, in_byte2, in_byte3, avail_bytes, code_in,
    input  ready
  );
  modport sink (
    input  valid, opcode, in_byte0, in_byte1, in_byte2, in_byte3, avail_bytes, code_in,
    output ready
  );
endinterface

interface u8u32cc_out_if;
  logic        valid;
  logic        ready;
  logic        ok;
  logic [2:0]  length;
  logic [20:0] code_out;
  logic [7:0]  out_byte0;
  logic [7:0]  out_byte1;
  logic [7:0]  out_byte2;
  logic [7:0]  out_byte3;
  logic [2:0]  subpart_len;

  modport source (
    output valid, ok, length, code_out, out_byte0, out_byte1, out_byte2, out_byte3,
           subpart_len,
    input  ready
  );
  modport sink (
    input  valid, ok, length, code_out, out_byte0, out_byte1, out_byte2, out_byte3,
           subpart_len,
    output ready
  );
endinterface

/* design/utf8_utf32_codepoint_convert.sv */
// ----------------------------------------------------------------------------
// utf8_utf32_codepoint_convert
// Converts one Unicode code point per transfer: decode of a strict UTF-8
// window of up to four bytes, or encode of a UTF-32 value into one to four
// bytes. An item is taken every clock cycle unless both registers are full
// and the output stalls. Items pass the input register, then the result
// register, with single-pass decoder and encoder logic between. A stalled
// output holds its result while one more item waits in the input register.
// ----------------------------------------------------------------------------
`include "utf8_utf32_codepoint_convert_defines.svh"

module utf8_utf32_codepoint_convert (
  input  logic          clk_i,
  input  logic          rst_ni,
  u8u32cc_in_if.sink    in_i,
  u8u32cc_out_if.source out_o
);

  typedef struct packed {
    logic        opcode;
    logic [7:0]  in_byte0;
    logic [7:0]  in_byte1;
    logic [7:0]  in_byte2;
    logic [7:0]  in_byte3;
    logic [2:0]  avail_bytes;
    logic [31:0] code_in;
  } item_t;

  logic              in_valid_q;
  item_t             in_item_q;
  logic              out_valid_q;
  u8u32cc_pkg::res_t out_res_q;
  u8u32cc_pkg::res_t out_res_d;
  u8u32cc_pkg::res_t dec_res;
  u8u32cc_pkg::res_t enc_res;
  logic              out_free;
  logic              in_free;

  assign out_free   = !out_valid_q || out_o.ready;
  assign in_free    = !in_valid_q || out_free;
  assign in_i.ready = in_free;

  u8u32cc_decode u_decode (
    .byte0_i (in_item_q.in_byte0),
    .byte1_i (in_item_q.in_byte1),
    .byte2_i (in_item_q.in_byte2),
    .byte3_i (in_item_q.in_byte3),
    .avail_i (in_item_q.avail_bytes),
    .res_o   (dec_res)
  );

  u8u32cc_encode u_encode (
    .code_i (in_item_q.code_in),
    .res_o  (enc_res)
  );

  assign out_res_d = (in_item_q.opcode == u8u32cc_pkg::OP_ENCODE) ? enc_res : dec_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_free) begin
        in_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_free) begin
      in_item_q.opcode      <= in_i.opcode;
      in_item_q.in_byte0    <= in_i.in_byte0;
      in_item_q.in_byte1    <= in_i.in_byte1;
      in_item_q.in_byte2    <= in_i.in_byte2;
      in_item_q.in_byte3    <= in_i.in_byte3;
      in_item_q.avail_bytes <= in_i.avail_bytes;
      in_item_q.code_in     <= in_i.code_in;
    end
    if (in_valid_q && out_free) begin
      out_res_q <= out_res_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.ok          = out_res_q.ok;
  assign out_o.length      = out_res_q.length;
  assign out_o.code_out    = out_res_q.code_out;
  assign out_o.out_byte0   = out_res_q.out_byte0;
  assign out_o.out_byte1   = out_res_q.out_byte1;
  assign out_o.out_byte2   = out_res_q.out_byte2;
  assign out_o.out_byte3   = out_res_q.out_byte3;
  assign out_o.subpart_len = out_res_q.subpart_len;

  `U8U_ASSERT_NEXT(a_accept_loads, in_i.valid && in_i.ready, in_valid_q,
                   "accepted transfer not held in input register")

  `U8U_ASSERT_IMP(a_full_stall_blocks, in_valid_q && out_valid_q && !out_o.ready,
                  !in_i.ready, "input taken while both stages are full")

  `U8U_ASSERT_IMP(a_ok_consistent, out_valid_q && out_res_q.ok,
                  (out_res_q.length != 3'd0) && (out_res_q.subpart_len == 3'd0),
                  "successful result with zero length or a subpart")

  `U8U_ASSERT(a_error_clean,
              !out_valid_q || out_res_q.ok ||
              ((out_res_q.length == 3'd0) && (out_res_q.code_out == 21'd0)),
              "failed result carries a length or code point")

endmodule

/* design/u8u32cc_decode.sv */
// ----------------------------------------------------------------------------
// u8u32cc_decode
// strict utf-8 decoder for one code point with maximal subpart on error
// ----------------------------------------------------------------------------
module u8u32cc_decode (
  input  logic [7:0]        byte0_i,
  input  logic [7:0]        byte1_i,
  input  logic [7:0]        byte2_i,
  input  logic [7:0]        byte3_i,
  input  logic [2:0]        avail_i,
  output u8u32cc_pkg::res_t res_o
);

  function automatic logic is_cont(input logic [7:0] b);
    return (b >= u8u32cc_pkg::CONT_MIN) && (b <= u8u32cc_pkg::CONT_MAX);
  endfunction

  logic [2:0] win;
  logic [2:0] need;
  logic [2:0] k;
  logic [7:0] lo;
  logic [7:0] hi;
  logic       bad_lead;

  always_comb begin
    res_o = '0;

    win = (avail_i > u8u32cc_pkg::MAX_WIN) ? u8u32cc_pkg::MAX_WIN : avail_i;
    if (win >= 3'd2 && byte1_i == 8'h00) begin
      win = 3'd1;
    end else if (win >= 3'd3 && byte2_i == 8'h00) begin
      win = 3'd2;
    end else if (win >= 3'd4 && byte3_i == 8'h00) begin
      win = 3'd3;
    end

    // lead byte class and second byte range
    lo       = u8u32cc_pkg::CONT_MIN;
    hi       = u8u32cc_pkg::CONT_MAX;
    need     = 3'd0;
    bad_lead = 1'b0;
    if (byte0_i <= u8u32cc_pkg::ASCII_MAX) begin
      need = 3'd1;
    end else if (byte0_i >= u8u32cc_pkg::LEAD2_MIN && byte0_i <= u8u32cc_pkg::LEAD2_MAX) begin
      need = 3'd2;
    end else if (byte0_i >= u8u32cc_pkg::LEAD3_MIN && byte0_i <= u8u32cc_pkg::LEAD3_MAX) begin
      need = 3'd3;
      if (byte0_i == u8u32cc_pkg::LEAD3_MIN) lo = u8u32cc_pkg::E0_CONT_MIN;
      if (byte0_i == u8u32cc_pkg::LEAD_SURR) hi = u8u32cc_pkg::ED_CONT_MAX;
    end else if (byte0_i >= u8u32cc_pkg::LEAD4_MIN && byte0_i <= u8u32cc_pkg::LEAD4_MAX) begin
      need = 3'd4;
      if (byte0_i == u8u32cc_pkg::LEAD4_MIN) lo = u8u32cc_pkg::F0_CONT_MIN;
      if (byte0_i == u8u32cc_pkg::LEAD4_MAX) hi = u8u32cc_pkg::F4_CONT_MAX;
    end else begin
      bad_lead = 1'b1;
    end

    // length of the valid prefix
    k = 3'd1;
    if (win > 3'd1 && byte1_i >= lo && byte1_i <= hi) begin
      k = 3'd2;
      if (need > 3'd2 && win > 3'd2 && is_cont(byte2_i)) begin
        k = 3'd3;
        if (need > 3'd3 && win > 3'd3 && is_cont(byte3_i)) begin
          k = 3'd4;
        end
      end
    end

    if (win == 3'd0) begin
      res_o = '0;
    end else if (need == 3'd1) begin
      res_o.ok       = 1'b1;
      res_o.length   = 3'd1;
      res_o.code_out = {13'd0, byte0_i};
    end else if (bad_lead) begin
      res_o.subpart_len = 3'd1;
    end else if (k < need) begin
      res_o.subpart_len = k;
    end else begin
      res_o.ok     = 1'b1;
      res_o.length = need;
      case (need)
        3'd2:    res_o.code_out = {10'd0, byte0_i[4:0], byte1_i[5:0]};
        3'd3:    res_o.code_out = {5'd0, byte0_i[3:0], byte1_i[5:0], byte2_i[5:0]};
        default: res_o.code_out = {byte0_i[2:0], byte1_i[5:0], byte2_i[5:0], byte3_i[5:0]};
      endcase
    end
  end

endmodule

/* design/u8u32cc_encode.sv */
// ----------------------------------------------------------------------------
// u8u32cc_encode
// utf-32 to utf-8 encoder for one code point
// ----------------------------------------------------------------------------
module u8u32cc_encode (
  input  logic [31:0]       code_i,
  output u8u32cc_pkg::res_t res_o
);

  always_comb begin
    res_o = '0;
    if (code_i <= u8u32cc_pkg::ONE_BYTE_MAX) begin
      res_o.ok        = 1'b1;
      res_o.length    = 3'd1;
      res_o.out_byte0 = code_i[7:0];
    end else if (code_i <= u8u32cc_pkg::TWO_BYTE_MAX) begin
      res_o.ok        = 1'b1;
      res_o.length    = 3'd2;
      res_o.out_byte0 = {3'b110, code_i[10:6]};
      res_o.out_byte1 = {2'b10, code_i[5:0]};
    end else if (code_i <= u8u32cc_pkg::THREE_BYTE_MAX) begin
      if (code_i < u8u32cc_pkg::SURR_MIN || code_i > u8u32cc_pkg::SURR_MAX) begin
        res_o.ok        = 1'b1;
        res_o.length    = 3'd3;
        res_o.out_byte0 = {4'b1110, code_i[15:12]};
        res_o.out_byte1 = {2'b10, code_i[11:6]};
        res_o.out_byte2 = {2'b10, code_i[5:0]};
      end
    end else if (code_i <= u8u32cc_pkg::MAX_CODE_POINT) begin
      res_o.ok        = 1'b1;
      res_o.length    = 3'd4;
      res_o.out_byte0 = {5'b11110, code_i[20:18]};
      res_o.out_byte1 = {2'b10, code_i[17:12]};
      res_o.out_byte2 = {2'b10, code_i[11:6]};
      res_o.out_byte3 = {2'b10, code_i[5:0]};
    end
  end

endmodule
